// File: hw/rtl/gls_pkg.sv
// Package: shared types and constants for the gamepad link sequencer.
`timescale 1ns / 1ps
`default_nettype none
package gls_pkg;

	typedef enum logic [1:0] {
		LINK_ABSENT   = 2'd0,
		LINK_STARTING = 2'd1,
		LINK_READY    = 2'd2
	} link_t;

	localparam logic [1:0] CMD_SERVICE = 2'd0;
	localparam logic [1:0] CMD_REQUEST = 2'd1;
	localparam logic [1:0] CMD_COLLECT = 2'd2;

	localparam logic [2:0] TX_NONE        = 3'd0;
	localparam logic [2:0] TX_WRITE_ENA   = 3'd1;
	localparam logic [2:0] TX_WRITE_HIRES = 3'd2;
	localparam logic [2:0] TX_WRITE_MODE  = 3'd3;
	localparam logic [2:0] TX_PTR_ID      = 3'd4;
	localparam logic [2:0] TX_ID_READ     = 3'd5;
	localparam logic [2:0] TX_PTR_REPORT  = 3'd6;
	localparam logic [2:0] TX_REPORT_READ = 3'd7;

	localparam logic [2:0] STEP_NONE    = 3'd0;
	localparam logic [2:0] STEP_HIRES   = 3'd1;
	localparam logic [2:0] STEP_MODE    = 3'd2;
	localparam logic [2:0] STEP_PTR_ID  = 3'd3;
	localparam logic [2:0] STEP_ID_READ = 3'd4;

	localparam logic [31:0] DELAY_AFTER_ENA   = 32'd10;
	localparam logic [31:0] DELAY_AFTER_HIRES = 32'd20;
	localparam logic [31:0] DELAY_AFTER_MODE  = 32'd2;
	localparam logic [31:0] DELAY_AFTER_PTR   = 32'd1;

	localparam logic [7:0] CODE_ACK      = 8'd0;
	localparam logic [7:0] ID_READ_LEN   = 8'd6;
	localparam logic [7:0] REPORT_LEN    = 8'd8;
	localparam logic [7:0] ID_BYTE_2     = 8'hA4;
	localparam logic [7:0] ID_BYTE_3     = 8'h20;
	localparam logic [7:0] WRONG_ID_CODE = 8'hA4;

	localparam logic [15:0] RETRY_RESET_MS = 16'd1000;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] now_ms;
		logic [7:0]  bus_code;
		logic [7:0]  byte_a;
		logic [7:0]  byte_b;
		logic [7:0]  byte_c;
		logic [7:0]  byte_d;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  transaction;
		logic [1:0]  link_state;
		logic [2:0]  init_step;
		logic [14:0] buttons;
		logic        hires;
		logic        requested;
		logic [15:0] connects;
		logic [15:0] drops;
		logic [2:0]  recent_fail_step;
		logic [7:0]  recent_fail_code;
	} out_item_t;

	typedef struct packed {
		link_t       link;
		logic [2:0]  step;
		logic [31:0] due;
		logic        pending;
		logic [14:0] buttons;
		logic        hires;
		logic [15:0] connects;
		logic [15:0] drops;
		logic [2:0]  fail_step;
		logic [7:0]  fail_code;
	} gls_state_t;

endpackage
`default_nettype wire

// File: hw/rtl/gls_unpack.sv
// Button decoder: active-low report bytes to 15 pressed-button bits.
`timescale 1ns / 1ps
`default_nettype none
module gls_unpack (
	input  wire logic [7:0]  hi,
	input  wire logic [7:0]  lo,
	output logic      [14:0] buttons
);
	logic [7:0] h;
	logic [7:0] l;

	assign h = ~hi;
	assign l = ~lo;

	// bit order: up down left right a b x y l r zl zr start select home
	assign buttons = {h[3], h[4], h[2], l[2], l[7], h[1], h[5], l[5],
	                  l[3], l[6], l[4], h[7], l[1], h[6], l[0]};
endmodule
`default_nettype wire

// File: hw/rtl/gls_step.sv
// Next-state logic: one request against the current link state.
`timescale 1ns / 1ps
`default_nettype none
module gls_step (
	input  wire gls_pkg::gls_state_t cur,
	input  wire gls_pkg::in_item_t   item,
	input  wire logic [15:0]         retry_ms,
	output gls_pkg::gls_state_t      nxt,
	output logic [2:0]               transaction
);
	logic        not_due;
	logic        drop;
	logic        use_hires;
	logic [31:0] elapsed;
	logic [7:0]  sel_hi;
	logic [7:0]  sel_lo;
	logic [14:0] decoded;

	assign elapsed   = item.now_ms - cur.due;
	assign not_due   = elapsed[31];
	assign use_hires = (item.byte_c != 8'd0) || (item.byte_d != 8'd0);
	assign sel_hi    = use_hires ? item.byte_c : item.byte_a;
	assign sel_lo    = use_hires ? item.byte_d : item.byte_b;

	gls_unpack u_unpack (
		.hi      (sel_hi),
		.lo      (sel_lo),
		.buttons (decoded)
	);

	always_comb begin
		nxt         = cur;
		transaction = gls_pkg::TX_NONE;
		drop        = 1'b0;
		unique case (item.command)
			gls_pkg::CMD_SERVICE: begin
				if (cur.link != gls_pkg::LINK_READY && !not_due) begin
					if (cur.link == gls_pkg::LINK_ABSENT) begin
						transaction = gls_pkg::TX_WRITE_ENA;
						if (item.bus_code != gls_pkg::CODE_ACK) begin
							nxt.fail_step = gls_pkg::STEP_NONE;
							nxt.fail_code = item.bus_code;
							drop = 1'b1;
						end else begin
							nxt.link = gls_pkg::LINK_STARTING;
							nxt.step = gls_pkg::STEP_HIRES;
							nxt.due  = item.now_ms + gls_pkg::DELAY_AFTER_ENA;
						end
					end else begin
						unique case (cur.step)
							gls_pkg::STEP_HIRES: begin
								transaction = gls_pkg::TX_WRITE_HIRES;
								if (item.bus_code != gls_pkg::CODE_ACK) begin
									nxt.fail_step = gls_pkg::STEP_HIRES;
									nxt.fail_code = item.bus_code;
									drop = 1'b1;
								end else begin
									nxt.step = gls_pkg::STEP_MODE;
									nxt.due  = item.now_ms + gls_pkg::DELAY_AFTER_HIRES;
								end
							end
							gls_pkg::STEP_MODE: begin
								// refusal here is noted but not fatal
								transaction = gls_pkg::TX_WRITE_MODE;
								if (item.bus_code != gls_pkg::CODE_ACK) begin
									nxt.fail_step = gls_pkg::STEP_MODE;
									nxt.fail_code = item.bus_code;
								end
								nxt.step = gls_pkg::STEP_PTR_ID;
								nxt.due  = item.now_ms + gls_pkg::DELAY_AFTER_MODE;
							end
							gls_pkg::STEP_PTR_ID: begin
								transaction = gls_pkg::TX_PTR_ID;
								if (item.bus_code != gls_pkg::CODE_ACK) begin
									nxt.fail_step = gls_pkg::STEP_PTR_ID;
									nxt.fail_code = item.bus_code;
									drop = 1'b1;
								end else begin
									nxt.step = gls_pkg::STEP_ID_READ;
									nxt.due  = item.now_ms + gls_pkg::DELAY_AFTER_PTR;
								end
							end
							gls_pkg::STEP_ID_READ: begin
								transaction = gls_pkg::TX_ID_READ;
								if (item.bus_code != gls_pkg::ID_READ_LEN) begin
									nxt.fail_step = gls_pkg::STEP_ID_READ;
									nxt.fail_code = item.bus_code;
									drop = 1'b1;
								end else if (item.byte_a != gls_pkg::ID_BYTE_2 ||
								             item.byte_b != gls_pkg::ID_BYTE_3) begin
									nxt.fail_step = gls_pkg::STEP_ID_READ;
									nxt.fail_code = gls_pkg::WRONG_ID_CODE;
									drop = 1'b1;
								end else begin
									nxt.link     = gls_pkg::LINK_READY;
									nxt.connects = cur.connects + 16'd1;
									nxt.pending  = 1'b0;
								end
							end
							default: begin
								transaction = gls_pkg::TX_NONE;
							end
						endcase
					end
				end
			end
			gls_pkg::CMD_REQUEST: begin
				if (cur.link == gls_pkg::LINK_READY) begin
					transaction = gls_pkg::TX_PTR_REPORT;
					if (item.bus_code != gls_pkg::CODE_ACK) begin
						drop = 1'b1;
					end else begin
						nxt.pending = 1'b1;
					end
				end
			end
			gls_pkg::CMD_COLLECT: begin
				if (cur.link == gls_pkg::LINK_READY && cur.pending) begin
					transaction = gls_pkg::TX_REPORT_READ;
					nxt.pending = 1'b0;
					if (item.bus_code != gls_pkg::REPORT_LEN) begin
						drop = 1'b1;
					end else begin
						nxt.hires   = use_hires;
						nxt.buttons = decoded;
					end
				end
			end
			default: begin
				transaction = gls_pkg::TX_NONE;
			end
		endcase

		if (drop) begin
			if (cur.link == gls_pkg::LINK_READY) begin
				nxt.drops = cur.drops + 16'd1;
			end
			nxt.link    = gls_pkg::LINK_ABSENT;
			nxt.buttons = 15'd0;
			nxt.pending = 1'b0;
			nxt.due     = item.now_ms + {16'd0, retry_ms};
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/gamepad_link_sequencer_top.sv
// Top level: gamepad link sequencer with input, state and result registers.
// A request is held in the input stage, passes the next-state logic and is registered in the result register.
// Throughput: one request per cycle while each result is taken; the single next-state pass sets the pace.
// in_ready drops only while the input stage holds a request and the result waits.
// Reset (arst_n low, async): link absent, all counters and flags zero,
// retry delay 1000 ms, no request in flight and no result shown.
`timescale 1ns / 1ps
`default_nettype none
module gamepad_link_sequencer_top (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire gls_pkg::in_item_t in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output gls_pkg::out_item_t    out_data,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [15:0]      cfg_data
);
	// input stage
	logic               valid_s1;
	gls_pkg::in_item_t  item_s1;
	// link state, updated as each request moves into the result register
	gls_pkg::gls_state_t state_q;
	gls_pkg::gls_state_t state_nxt;
	logic [2:0]          tx_nxt;
	logic [15:0]         retry_q;
	// result register
	logic                out_valid_q;
	gls_pkg::out_item_t  out_data_q;
	logic                advance;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	gls_step u_step (
		.cur         (state_q),
		.item        (item_s1),
		.retry_ms    (retry_q),
		.nxt         (state_nxt),
		.transaction (tx_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_q <= gls_pkg::RETRY_RESET_MS;
		end else if (cfg_valid && cfg_ready) begin
			retry_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{link: gls_pkg::LINK_ABSENT, default: '0};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result fields report the state after the update
	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q.transaction      <= tx_nxt;
			out_data_q.link_state       <= state_nxt.link;
			out_data_q.init_step        <= state_nxt.step;
			out_data_q.buttons          <= state_nxt.buttons;
			out_data_q.hires            <= state_nxt.hires;
			out_data_q.requested        <= state_nxt.pending;
			out_data_q.connects         <= state_nxt.connects;
			out_data_q.drops            <= state_nxt.drops;
			out_data_q.recent_fail_step <= state_nxt.fail_step;
			out_data_q.recent_fail_code <= state_nxt.fail_code;
		end
	end

`ifndef SYNTHESIS
	a_ready_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.link == gls_pkg::LINK_READY |-> state_q.step == gls_pkg::STEP_ID_READ)
		else $error("link ready without finished start-up");

	a_pending_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pending |-> state_q.link == gls_pkg::LINK_READY)
		else $error("report pending while link not ready");

	a_buttons_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.buttons != 15'd0 |-> state_q.link == gls_pkg::LINK_READY)
		else $error("buttons held while link not ready");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("link state changed without a request moving");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !out_ready) |-> !in_ready)
		else $error("input taken while both stages are full");
`endif
endmodule
`default_nettype wire
